// ----- sv/apll_divider_search_core_macros.svh -----
// assertion macros for the pll divider search core
`ifndef APLL_DIVIDER_SEARCH_CORE_MACROS_SVH
`define APLL_DIVIDER_SEARCH_CORE_MACROS_SVH

// same-cycle implication
`define APDS_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define APDS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ----- sv/apds_pkg.sv -----
// shared types and constants of the pll divider search core
`default_nettype none
package apds_pkg;
   localparam int unsigned XTAL_W = 6;
   localparam int unsigned TGT_W = 23;
   localparam int unsigned SDM_W = 21;
   localparam int unsigned ERR_W = 21;
   localparam int unsigned DEN_W = 7;
   localparam int unsigned DIV_W = 5;
   localparam int unsigned RECIP_W = 32;
   localparam logic [XTAL_W-1:0] XTAL_RESET = 6'd40;
   localparam logic [29:0] TN_LOW = 30'd22937600;
   localparam logic [29:0] TN_HIGH = 30'd32768000;
   localparam logic [21:0] SDM_OFFSET = 22'd262140;

   typedef struct packed {
      logic have;
      logic [SDM_W-1:0] sdm;
      logic [DIV_W-1:0] div;
      logic [ERR_W-1:0] err;
      logic [DEN_W-1:0] den;
   } best_type;
endpackage
`default_nettype wire

// ----- sv/apds_cell.sv -----
// one divider cell: four stages that test one divider and update the best item
`default_nettype none
module apds_cell #(
   parameter int unsigned DIV_INDEX = 0
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic [apds_pkg::XTAL_W-1:0] xtal,
   input  wire logic [apds_pkg::RECIP_W-1:0] recip,
   input  wire logic up_valid,
   input  wire logic [apds_pkg::TGT_W-1:0] up_t,
   input  wire apds_pkg::best_type up_best,
   output logic up_hold,
   output logic dn_valid,
   output logic [apds_pkg::TGT_W-1:0] dn_t,
   output apds_pkg::best_type dn_best,
   input  wire logic dn_hold
);
   import apds_pkg::*;

   localparam logic [DEN_W-1:0] DEN = DEN_W'(2 * (DIV_INDEX + 2));

   logic v1_ff, v2_ff, v3_ff, v4_ff;
   logic v1_in, v2_in, v3_in, v4_in;
   logic h1, h2, h3, h4;

   logic [TGT_W-1:0] t1_ff, t2_ff, t3_ff, t4_ff, t1_in, t2_in, t3_in, t4_in;
   best_type b1_ff, b2_ff, b3_ff, b4_ff, b1_in, b2_in, b3_in, b4_in;
   logic [24:0] tn1_ff, tn2_ff, tn1_in, tn2_in;
   logic [24:0] n1_ff, n1_in;
   logic ok1_ff, ok2_ff, ok3_ff, ok1_in, ok2_in, ok3_in;
   logic [25:0] q2_ff, q2_in;
   logic [SDM_W-1:0] sdm3_ff, sdm3_in;
   logic [ERR_W-1:0] e3_ff, e3_in;

   logic [29:0] tn_full;
   logic [43:0] ac, bb, nn;
   logic [56:0] prod;
   logic [27:0] mulx;
   logic [43:0] ach, want, diff;
   logic [27:0] lhs, rhs;
   logic better;

   assign h4 = v4_ff & dn_hold;
   assign h3 = v3_ff & h4;
   assign h2 = v2_ff & h3;
   assign h1 = v1_ff & h2;
   assign up_hold = h1;

   // stage 1: range check and rounded numerator
   always_comb begin
      tn_full = 30'(up_t) * 30'(DEN);
      ac = 44'(tn_full[24:0]) * 44'd131070 + (44'(xtal) << 16);
      bb = 44'(xtal) * 44'd34359214080;
      nn = ac - bb;
      v1_in = h1 ? v1_ff : up_valid;
      t1_in = h1 ? t1_ff : up_t;
      b1_in = h1 ? b1_ff : up_best;
      tn1_in = h1 ? tn1_ff : tn_full[24:0];
      n1_in = h1 ? n1_ff : nn[41:17];
      ok1_in = h1 ? ok1_ff : ((tn_full >= TN_LOW) && (tn_full <= TN_HIGH) &&
                               (ac >= bb) && (xtal != '0));
   end

   // stage 2: divide by the crystal through its reciprocal
   always_comb begin
      prod = 57'(n1_ff) * 57'(recip);
      v2_in = h2 ? v2_ff : v1_ff;
      t2_in = h2 ? t2_ff : t1_ff;
      b2_in = h2 ? b2_ff : b1_ff;
      tn2_in = h2 ? tn2_ff : tn1_ff;
      ok2_in = h2 ? ok2_ff : ok1_ff;
      q2_in = h2 ? q2_ff : prod[56:31];
   end

   // stage 3: word limit and scaled error
   always_comb begin
      mulx = 28'(xtal) * 28'(q2_ff[SDM_W-1:0] + SDM_OFFSET);
      ach = {mulx, 16'd0};
      want = 44'(tn2_ff) * 44'd65535;
      diff = (ach >= want) ? (ach - want) : (want - ach);
      v3_in = h3 ? v3_ff : v2_ff;
      t3_in = h3 ? t3_ff : t2_ff;
      b3_in = h3 ? b3_ff : b2_ff;
      ok3_in = h3 ? ok3_ff : (ok2_ff && (q2_ff[25:SDM_W] == '0));
      sdm3_in = h3 ? sdm3_ff : q2_ff[SDM_W-1:0];
      e3_in = h3 ? e3_ff : diff[ERR_W-1:0];
   end

   // stage 4: cross-multiplied compare against the best so far
   always_comb begin
      lhs = 28'(e3_ff) * 28'(b3_ff.den);
      rhs = 28'(b3_ff.err) * 28'(DEN);
      better = !b3_ff.have || (lhs < rhs);
      v4_in = h4 ? v4_ff : v3_ff;
      t4_in = h4 ? t4_ff : t3_ff;
      b4_in = b4_ff;
      if (!h4) begin
         b4_in = b3_ff;
         if (ok3_ff && better) begin
            b4_in.have = 1'b1;
            b4_in.sdm = sdm3_ff;
            b4_in.div = DIV_W'(DIV_INDEX);
            b4_in.err = e3_ff;
            b4_in.den = DEN;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
         v4_ff <= v4_in;
      end
   end

   always_ff @(posedge clock) begin
      t1_ff <= t1_in;
      t2_ff <= t2_in;
      t3_ff <= t3_in;
      t4_ff <= t4_in;
      b1_ff <= b1_in;
      b2_ff <= b2_in;
      b3_ff <= b3_in;
      b4_ff <= b4_in;
      tn1_ff <= tn1_in;
      tn2_ff <= tn2_in;
      n1_ff <= n1_in;
      ok1_ff <= ok1_in;
      ok2_ff <= ok2_in;
      ok3_ff <= ok3_in;
      q2_ff <= q2_in;
      sdm3_ff <= sdm3_in;
      e3_ff <= e3_in;
   end

   assign dn_valid = v4_ff;
   assign dn_t = t4_ff;
   assign dn_best = b4_ff;
endmodule
`default_nettype wire

// ----- sv/apll_divider_search_core.sv -----
// top level of the pll divider search core
`default_nettype none
// Searches the output dividers for the pll setting whose achieved frequency is
// closest to the wanted one. Each item flows through a chain of NUM_DIVIDERS
// cells, one per divider, each four stages deep, then an output register. One
// item is taken every cycle that req_stall is low. A stall on the result side
// holds only the stages that carry items, so empty stages keep filling. The
// crystal register may be written only while idle.
`include "apll_divider_search_core_macros.svh"
module apll_divider_search_core #(
   parameter int unsigned NUM_DIVIDERS = 32
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic csr_valid,
   output logic csr_ready,
   input  wire logic [apds_pkg::XTAL_W-1:0] csr_xtal_mhz,
   input  wire logic req_valid,
   output logic req_stall,
   input  wire logic [apds_pkg::TGT_W-1:0] req_target_freq_q16,
   output logic rsp_valid,
   input  wire logic rsp_stall,
   output logic rsp_found,
   output logic [7:0] rsp_sdm_byte0,
   output logic [7:0] rsp_sdm_byte1,
   output logic [4:0] rsp_sdm_top5,
   output logic [apds_pkg::DIV_W-1:0] rsp_post_div
);
   import apds_pkg::*;

   logic [XTAL_W-1:0] xtal_ff, xtal_in;
   logic [RECIP_W-1:0] recip_tab [64];
   logic [RECIP_W-1:0] recip;

   logic link_valid [NUM_DIVIDERS+1];
   logic [TGT_W-1:0] link_t [NUM_DIVIDERS+1];
   best_type link_best [NUM_DIVIDERS+1];
   logic link_hold [NUM_DIVIDERS+1];

   logic rsp_valid_ff, rsp_valid_in;
   best_type rsp_best_ff, rsp_best_in;
   logic out_hold;

   assign csr_ready = 1'b1;
   assign xtal_in = (csr_valid && csr_ready) ? csr_xtal_mhz : xtal_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         xtal_ff <= XTAL_RESET;
      end else begin
         xtal_ff <= xtal_in;
      end
   end

   // ceil(2^31 / x) for every nonzero crystal value, 2^31 for zero
   for (genvar g = 0; g < 64; g++) begin : g_recip
      localparam longint unsigned K = (g == 0) ? 1 : g;
      localparam logic [RECIP_W-1:0] R = RECIP_W'((64'd2147483648 + K - 64'd1) / K);
      assign recip_tab[g] = R;
   end
   assign recip = recip_tab[xtal_ff];

   assign link_valid[0] = req_valid;
   assign link_t[0] = req_target_freq_q16;
   assign link_best[0] = '{have: 1'b0, sdm: '0, div: '0, err: '0, den: DEN_W'(1)};
   assign req_stall = link_hold[0];

   for (genvar i = 0; i < NUM_DIVIDERS; i++) begin : g_cell
      apds_cell #(.DIV_INDEX(i)) u_cell (
         .clock   (clock),
         .reset   (reset),
         .xtal    (xtal_ff),
         .recip   (recip),
         .up_valid(link_valid[i]),
         .up_t    (link_t[i]),
         .up_best (link_best[i]),
         .up_hold (link_hold[i]),
         .dn_valid(link_valid[i+1]),
         .dn_t    (link_t[i+1]),
         .dn_best (link_best[i+1]),
         .dn_hold (link_hold[i+1])
      );
   end

   assign out_hold = rsp_valid_ff & rsp_stall;
   assign link_hold[NUM_DIVIDERS] = out_hold;
   assign rsp_valid_in = out_hold ? rsp_valid_ff : link_valid[NUM_DIVIDERS];
   assign rsp_best_in = out_hold ? rsp_best_ff : link_best[NUM_DIVIDERS];

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_best_ff <= rsp_best_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_found = rsp_best_ff.have;
   assign rsp_sdm_byte0 = rsp_best_ff.sdm[7:0];
   assign rsp_sdm_byte1 = rsp_best_ff.sdm[15:8];
   assign rsp_sdm_top5 = rsp_best_ff.sdm[20:16];
   assign rsp_post_div = rsp_best_ff.div;

   `APDS_ASSERT_NOW(a_none_is_zero, clock, reset, rsp_valid_ff && !rsp_best_ff.have, (rsp_best_ff.sdm == '0) && (rsp_best_ff.div == '0))
   `APDS_ASSERT_NOW(a_div_in_range, clock, reset, rsp_valid_ff && rsp_best_ff.have, 32'(rsp_best_ff.div) < NUM_DIVIDERS)
   `APDS_ASSERT_NEXT(a_xtal_held, clock, reset, !csr_valid, xtal_ff == $past(xtal_ff))
endmodule
`default_nettype wire

// ----- tb/tb_apll_divider_search_core.sv -----
// testbench of the pll divider search core: queued driver, monitor and exact-integer predictor
`default_nettype none
module tb_apll_divider_search_core;
   import apds_pkg::*;

   localparam int unsigned NUM_DIVIDERS = 32;
   localparam int unsigned LATENCY = 4 * NUM_DIVIDERS + 1;
   localparam int unsigned ITEM_COUNT = 600;

   typedef struct packed {
      logic found;
      logic [7:0] byte0;
      logic [7:0] byte1;
      logic [4:0] top5;
      logic [4:0] post_div;
   } setting_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [XTAL_W-1:0] csr_xtal_mhz = '0;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [TGT_W-1:0] req_target_freq_q16 = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic rsp_found;
   logic [7:0] rsp_sdm_byte0;
   logic [7:0] rsp_sdm_byte1;
   logic [4:0] rsp_sdm_top5;
   logic [DIV_W-1:0] rsp_post_div;

   logic [TGT_W-1:0] target_queue[$];
   setting_type setting_queue[$];
   logic [XTAL_W-1:0] xtal_model = XTAL_RESET;
   logic idle_allowed = 1'b1;
   int send_gap = 0;
   int stall_left = 0;
   int mismatches = 0;
   int results_seen = 0;
   int sent = 0;

   apll_divider_search_core #(.NUM_DIVIDERS(NUM_DIVIDERS)) u_top (
      .clock(clock), .reset(reset),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_xtal_mhz(csr_xtal_mhz),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_target_freq_q16(req_target_freq_q16),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_found(rsp_found),
      .rsp_sdm_byte0(rsp_sdm_byte0), .rsp_sdm_byte1(rsp_sdm_byte1),
      .rsp_sdm_top5(rsp_sdm_top5), .rsp_post_div(rsp_post_div)
   );

   always #10 clock = ~clock;

   function automatic setting_type search_dividers(logic [TGT_W-1:0] target,
                                                   logic [XTAL_W-1:0] xtal);
      setting_type res;
      longint den, tn, num2, q, ach, want, e, best_e, best_d, best_sdm;
      bit have;
      res = '0;
      have = 0;
      best_e = 0;
      best_d = 1;
      best_sdm = 0;
      if (xtal != 0) begin
         for (int d = 0; d < NUM_DIVIDERS; d++) begin
            den = 2 * (d + 2);
            tn = longint'(target) * den;
            if (tn < 350 * 65536 || tn > 500 * 65536) continue;
            num2 = 2 * (tn * 65535 - 4 * 65536 * 65535 * longint'(xtal))
                   + 65536 * longint'(xtal);
            if (num2 < 0) continue;
            q = num2 / (2 * 65536 * longint'(xtal));
            if (q > 2097151) continue;
            ach = 65536 * longint'(xtal) * (q + 4 * 65535);
            want = 65535 * tn;
            e = (ach >= want) ? ach - want : want - ach;
            if (!have || e * best_d < best_e * den) begin
               have = 1;
               best_sdm = q;
               res.post_div = d[4:0];
               best_e = e;
               best_d = den;
            end
         end
      end
      res.found = have;
      res.byte0 = best_sdm[7:0];
      res.byte1 = best_sdm[15:8];
      res.top5 = best_sdm[20:16];
      return res;
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!(req_valid && req_stall)) begin
         if (req_valid) begin
            setting_queue.push_back(search_dividers(req_target_freq_q16, xtal_model));
            sent++;
         end
         if (send_gap > 0) begin
            send_gap--;
            req_valid <= 1'b0;
         end else if (target_queue.size() > 0) begin
            req_valid <= 1'b1;
            req_target_freq_q16 <= target_queue.pop_front();
            if (idle_allowed && $urandom_range(0, 7) == 0) send_gap = $urandom_range(1, 10);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      setting_type got, want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            got = {rsp_found, rsp_sdm_byte0, rsp_sdm_byte1, rsp_sdm_top5, rsp_post_div};
            results_seen++;
            if (setting_queue.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected item: %p", got);
            end else begin
               want = setting_queue.pop_front();
               if (got !== want) begin
                  mismatches++;
                  if (mismatches <= 10) $display("mismatch: expected %p actual %p", want, got);
               end
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
            if (idle_allowed && $urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 10);
         end
      end
   end

   task automatic drain();
      while (target_queue.size() > 0 || req_valid || setting_queue.size() > 0)
         @(posedge clock);
      repeat (LATENCY + 5) @(posedge clock);
   endtask

   task automatic write_xtal(logic [XTAL_W-1:0] value);
      csr_valid <= 1'b1;
      csr_xtal_mhz <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      xtal_model = value;
   endtask

   // mostly targets that land in the usable band for some divider
   function automatic logic [TGT_W-1:0] pick_target();
      int r;
      r = $urandom_range(0, 9);
      if (r < 7) return TGT_W'($urandom_range(350 * 65536 / 66, 500 * 65536 / 4));
      if (r < 9) return TGT_W'($urandom);
      return TGT_W'($urandom_range(0, 3)) | (r[0] ? 23'h7FFFFC : 23'h0);
   endfunction

   initial begin
      logic [XTAL_W-1:0] xtals[5];
      xtals = '{6'd40, 6'd1, 6'd63, 6'd26, 6'd0};
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      target_queue = '{23'd0, 23'h7FFFFF, 23'd1, 23'h555555, 23'h2AAAAA,
                       23'd5734400, 23'd8192000, 23'd5734399, 23'd8192001,
                       23'd344064, 23'd349525, 23'd5242880, 23'd2621440, 23'd344063};
      drain();
      foreach (xtals[k]) begin
         write_xtal(xtals[k]);
         for (int i = 0; i < ITEM_COUNT / 5; i++) target_queue.push_back(pick_target());
         if (k == 4) idle_allowed = 1'b0;
         drain();
      end
      $display("covered %0d items over %0d crystal settings including 0, 1 and 63 MHz",
               sent, 6);
      $display("results checked: %0d", results_seen);
      if (mismatches == 0 && setting_queue.size() == 0) begin
         $display("tb_apll_divider_search_core: PASS");
      end else begin
         $display("tb_apll_divider_search_core: FAIL");
      end
      $finish;
   end

   initial begin
      #4000000;
      $display("tb_apll_divider_search_core: FAIL");
      $finish;
   end
endmodule
`default_nettype wire
